@@ rtl/core/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants for the lag pair matcher
// Record layout, command and status codes, table depth.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // table depth (number of cells in the record ring)
  localparam int MAX_RECORDS = 64;

  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;
  localparam int FIELD_W = 16;

  typedef struct packed {
    logic [FIELD_W-1:0] year;
    logic [FIELD_W-1:0] location;
    logic [FIELD_W-1:0] stratum;
    logic [FIELD_W-1:0] source;
  } record_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

endpackage

@@ rtl/core/lpm_cell.sv @@
// ----------------------------------------------------------------------------
// lpm_cell: one record slot of the ring
// Loads a new record on append, otherwise takes its neighbor's record on shift.
// ----------------------------------------------------------------------------
module lpm_cell
  import lpm_pkg::*;
(
  input  logic    clk,
  input  logic    wr_en,
  input  record_t wr_rec,
  input  logic    shift_en,
  input  record_t rec_in,
  output record_t rec_out
);

  record_t rec;

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec <= wr_rec;
    end else if (shift_en) begin
      rec <= rec_in;
    end
  end

  assign rec_out = rec;

endmodule

@@ rtl/core/lpm_ring.sv @@
// ----------------------------------------------------------------------------
// lpm_ring: circular chain of record cells
// Cell k takes from cell k+1 on shift, so the head shows record s after s
// shifts; a full turn of MAX_RECORDS shifts brings every record home.
// ----------------------------------------------------------------------------
module lpm_ring
  import lpm_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  record_t          wr_rec,
  input  logic             shift_en,
  output record_t          head
);

  record_t cell_rec [MAX_RECORDS];

  for (genvar k = 0; k < MAX_RECORDS; k++) begin : g_cell
    logic cell_wr;

    // write decode for this slot
    assign cell_wr = wr_en && (wr_index == IDX_W'(k));

    lpm_cell u_cell (
      .clk      (clk),
      .wr_en    (cell_wr),
      .wr_rec   (wr_rec),
      .shift_en (shift_en),
      .rec_in   (cell_rec[(k + 1) % MAX_RECORDS]),
      .rec_out  (cell_rec[k])
    );
  end

  assign head = cell_rec[0];

endmodule

@@ rtl/core/lag_pair_matcher.sv @@
// ----------------------------------------------------------------------------
// lag_pair_matcher: record table with one-year lag pair search
// Clear, append or query records; a query lists every stored record with the
// same location, stratum and source and a year exactly one less.
// ----------------------------------------------------------------------------
//  channel | signals                                      | transfer
//  command | start, busy, cmd, year, location, stratum,   | start && !busy
//          | source, query_index                          |
//  result  | strobe, newer_index, older_index, found,     | strobe (one cycle)
//          | status, last                                 |
//
// Clear, append and refused items: one result in the cycle after the transfer,
// busy stays low. A query turns the record ring twice, once to pick up the
// queried record and once to compare against each record in index order,
// then closes in a finishing state; busy stays high throughout. Pairs appear
// as found while the scan runs, the last one when it ends. Synchronous reset
// empties the table; no clearing pass. Results cannot stall.
// ----------------------------------------------------------------------------
module lag_pair_matcher
  import lpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [FIELD_W-1:0] year,
  input  logic [FIELD_W-1:0] location,
  input  logic [FIELD_W-1:0] stratum,
  input  logic [FIELD_W-1:0] source,
  input  logic [IDX_W-1:0]   query_index,
  output logic               strobe,
  output logic [IDX_W-1:0]   newer_index,
  output logic [IDX_W-1:0]   older_index,
  output logic               found,
  output logic [1:0]         status,
  output logic               last
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0]   LAST_STEP = IDX_W'(MAX_RECORDS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_RECORDS);

  state_t             state, state_next;
  logic [IDX_W-1:0]   step, step_next;
  logic [COUNT_W-1:0] record_count, record_count_next;
  logic [IDX_W-1:0]   qidx, qidx_next;
  record_t            key, key_next;
  logic               pend, pend_next;
  logic [IDX_W-1:0]   pend_idx, pend_idx_next;

  logic               strobe_next;
  logic [IDX_W-1:0]   newer_next, older_next;
  logic               found_next, last_next;
  status_t            status_next;

  logic               accept;
  logic               wr_en, shift_en;
  record_t            wr_rec, head;
  logic               hit;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  assign wr_rec.year     = year;
  assign wr_rec.location = location;
  assign wr_rec.stratum  = stratum;
  assign wr_rec.source   = source;

  lpm_ring u_ring (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_index (record_count[IDX_W-1:0]),
    .wr_rec   (wr_rec),
    .shift_en (shift_en),
    .head     (head)
  );

  // head record against the queried record; year + 1 formed without wrap
  assign hit = ({1'b0, step} < record_count) && (step != qidx) &&
               (head.location == key.location) && (head.stratum == key.stratum) &&
               (head.source == key.source) &&
               (({1'b0, head.year} + 17'd1) == {1'b0, key.year});

  // control and result selection
  always_comb begin
    state_next        = state;
    step_next         = step;
    record_count_next = record_count;
    qidx_next         = qidx;
    key_next          = key;
    pend_next         = pend;
    pend_idx_next     = pend_idx;
    wr_en             = 1'b0;
    shift_en          = 1'b0;
    strobe_next       = 1'b0;
    newer_next        = '0;
    older_next        = '0;
    found_next        = 1'b0;
    status_next       = STAT_OK;
    last_next         = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          case (cmd_t'(cmd))
            CMD_CLEAR: begin
              record_count_next = '0;
            end
            CMD_APPEND: begin
              if (record_count >= COUNT_MAX) begin
                status_next = STAT_FULL;
              end else begin
                wr_en             = 1'b1;
                record_count_next = record_count + COUNT_W'(1);
              end
            end
            CMD_QUERY: begin
              if ({1'b0, query_index} >= record_count) begin
                newer_next  = query_index;
                status_next = STAT_RANGE;
              end else begin
                strobe_next = 1'b0;
                qidx_next   = query_index;
                step_next   = '0;
                pend_next   = 1'b0;
                state_next  = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        // one full turn; grab the queried record as it passes the head
        shift_en  = 1'b1;
        step_next = step + IDX_W'(1);
        if (step == qidx) begin
          key_next = head;
        end
        if (step == LAST_STEP) begin
          step_next  = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // second turn; each hit releases the previous one as not last
        shift_en  = 1'b1;
        step_next = step + IDX_W'(1);
        if (hit) begin
          if (pend) begin
            strobe_next = 1'b1;
            newer_next  = qidx;
            older_next  = pend_idx;
            found_next  = 1'b1;
            last_next   = 1'b0;
          end
          pend_next     = 1'b1;
          pend_idx_next = step;
        end
        if (step == LAST_STEP) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        strobe_next = 1'b1;
        newer_next  = qidx;
        if (pend) begin
          older_next = pend_idx;
          found_next = 1'b1;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      record_count <= '0;
      pend         <= 1'b0;
      strobe       <= 1'b0;
      step         <= '0;
    end else begin
      state        <= state_next;
      record_count <= record_count_next;
      pend         <= pend_next;
      strobe       <= strobe_next;
      step         <= step_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    qidx        <= qidx_next;
    key         <= key_next;
    pend_idx    <= pend_idx_next;
    newer_index <= newer_next;
    older_index <= older_next;
    found       <= found_next;
    status      <= status_next;
    last        <= last_next;
  end

  // a matched pair is never a refusal
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && found |-> status == STAT_OK)
    else $error("found result with non-ok status");

  // a result without a pair closes its item
  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !found |-> last)
    else $error("not-found result not marked last");

  // the table never holds more than its depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    record_count <= COUNT_MAX)
    else $error("record count past table depth");

  // the scan position advances one record per cycle
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && step != LAST_STEP |=> step == $past(step) + IDX_W'(1))
    else $error("scan step did not advance");

endmodule

@@ bench/lag_pair_checker.sv @@
// ----------------------------------------------------------------------------
// lag_pair_checker: result predictor and scoreboard for the lag pair matcher
// Watches the command and result channels, keeps its own record table, works
// out the expected results of every command transfer and compares each
// result strobe field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module lag_pair_checker
  import lpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         cmd,
  input  logic [FIELD_W-1:0] year,
  input  logic [FIELD_W-1:0] location,
  input  logic [FIELD_W-1:0] stratum,
  input  logic [FIELD_W-1:0] source,
  input  logic [IDX_W-1:0]   query_index,
  input  logic               strobe,
  input  logic [IDX_W-1:0]   newer_index,
  input  logic [IDX_W-1:0]   older_index,
  input  logic               found,
  input  logic [1:0]         status,
  input  logic               last,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [IDX_W-1:0] newer;
    logic [IDX_W-1:0] older;
    logic             hit;
    status_t          stat;
    logic             tail;
  } lag_result_t;

  // shadow copy of the record table
  record_t            rec_table [MAX_RECORDS];
  logic [COUNT_W-1:0] rec_count;

  lag_result_t results_due [$];
  lag_result_t oldest_due;

  task automatic queue_result(input logic [IDX_W-1:0] newer, input logic [IDX_W-1:0] older,
                              input logic hit, input status_t stat, input logic tail);
    lag_result_t r;
    r.newer = newer;
    r.older = older;
    r.hit   = hit;
    r.stat  = stat;
    r.tail  = tail;
    results_due.insert(results_due.size(), r);
  endtask

  // expected results of one command transfer; updates the shadow table
  task automatic predict_lag_pairs(input logic [1:0] c, input record_t rec,
                                   input logic [IDX_W-1:0] qi);
    int          hits;
    lag_result_t final_pair;
    hits = 0;
    case (c)
      CMD_CLEAR: begin
        rec_count = '0;
        queue_result('0, '0, 1'b0, STAT_OK, 1'b1);
      end
      CMD_APPEND: begin
        if (rec_count >= MAX_RECORDS) begin
          queue_result('0, '0, 1'b0, STAT_FULL, 1'b1);
        end else begin
          rec_table[rec_count[IDX_W-1:0]] = rec;
          rec_count = rec_count + 1'b1;
          queue_result('0, '0, 1'b0, STAT_OK, 1'b1);
        end
      end
      CMD_QUERY: begin
        if ({1'b0, qi} >= rec_count) begin
          queue_result(qi, '0, 1'b0, STAT_RANGE, 1'b1);
        end else begin
          // scan every other record in index order; year sum kept one bit wider
          for (int j = 0; j < rec_count; j++) begin
            if (j != qi &&
                rec_table[j].location == rec_table[qi].location &&
                rec_table[j].stratum  == rec_table[qi].stratum  &&
                rec_table[j].source   == rec_table[qi].source   &&
                {1'b0, rec_table[j].year} + 17'd1 == {1'b0, rec_table[qi].year}) begin
              queue_result(qi, j[IDX_W-1:0], 1'b1, STAT_OK, 1'b0);
              hits++;
            end
          end
          if (hits == 0) begin
            queue_result(qi, '0, 1'b0, STAT_OK, 1'b1);
          end else begin
            final_pair = results_due.pop_back();
            final_pair.tail = 1'b1;
            results_due.insert(results_due.size(), final_pair);
          end
        end
      end
      default: begin
        queue_result('0, '0, 1'b0, STAT_OK, 1'b1);
      end
    endcase
  endtask

  function automatic int field_differs(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  // results are checked before the transfer of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      rec_count = '0;
      results_due.delete();
    end else begin
      if (strobe) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d/%0d",
                   $time, newer_index, older_index, found, status, last);
          errors++;
        end else begin
          oldest_due = results_due.pop_front();
          if (field_differs("newer_index", oldest_due.newer, newer_index) +
              field_differs("older_index", oldest_due.older, older_index) +
              field_differs("found", oldest_due.hit, found) +
              field_differs("status", oldest_due.stat, status) +
              field_differs("last", oldest_due.tail, last) != 0)
            errors++;
        end
      end
      if (start && !busy)
        predict_lag_pairs(cmd, '{year: year, location: location, stratum: stratum,
                                 source: source}, query_index);
    end
    pending <= results_due.size();
  end

endmodule

@@ bench/lag_pair_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// lag_pair_matcher_tb: command stimulus and verdict for the lag pair matcher
// Directed clear, append and query items cover empty tables, out of range
// queries, key mismatches and the top year; then random table builds with
// clustered keys and years, one filled past full, mostly queried in index order,
// under several sender idle rates. A watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module lag_pair_matcher_tb;
  import lpm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 2 * MAX_RECORDS + 12;
  localparam int ITEMS_PER_PHASE = 42;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         cmd;
  logic [FIELD_W-1:0] year;
  logic [FIELD_W-1:0] location;
  logic [FIELD_W-1:0] stratum;
  logic [FIELD_W-1:0] source;
  logic [IDX_W-1:0]   query_index;
  logic               strobe;
  logic [IDX_W-1:0]   newer_index;
  logic [IDX_W-1:0]   older_index;
  logic               found;
  logic [1:0]         status;
  logic               last;

  int errors;
  int pending;
  int items_sent;
  int records_held;
  int idle_pct;
  int quiet_cycles;

  lag_pair_matcher dut (.*);

  lag_pair_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic record_t rand_record();
    return record_t'({$urandom(), $urandom()});
  endfunction

  // one command transfer, then a random sender gap at the current idle rate
  task automatic send(input logic [1:0] c, input record_t rec, input logic [IDX_W-1:0] qi);
    int gap;
    start       <= 1'b1;
    cmd         <= c;
    year        <= rec.year;
    location    <= rec.location;
    stratum     <= rec.stratum;
    source      <= rec.source;
    query_index <= qi;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (c != CMD_UNUSED) items_sent++;
    if (c == CMD_CLEAR) records_held = 0;
    if (c == CMD_APPEND && records_held < MAX_RECORDS) records_held++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = ($urandom_range(7) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic append_rec(input record_t rec);
    send(CMD_APPEND, rec, IDX_W'($urandom()));
  endtask

  task automatic query_rec(input int qi);
    send(CMD_QUERY, rand_record(), qi[IDX_W-1:0]);
  endtask

  task automatic control(input logic [1:0] c);
    send(c, rand_record(), IDX_W'($urandom()));
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // clear, build a table from one or two key sets with nearby years, then query it
  task automatic run_scenario(input bit fill);
    record_t     key_pool [2];
    record_t     rec;
    logic [15:0] base;
    int          n;
    key_pool[0] = rand_record();
    key_pool[1] = rand_record();
    base = fill ? 16'($urandom_range(0, 16'hFFFE)) : 16'($urandom());
    n = fill ? MAX_RECORDS + 2 : $urandom_range(1, 12);
    control(CMD_CLEAR);
    for (int i = 0; i < n; i++) begin
      if (!fill && $urandom_range(9) == 0) begin
        if ($urandom_range(1) == 0) control(CMD_UNUSED);
        else query_rec($urandom_range(63));
      end
      rec = key_pool[fill ? 0 : $urandom_range(1)];
      if (fill) rec.year = (i == 0) ? base + 16'd1 : base;
      else rec.year = base + 16'($urandom_range(2));
      append_rec(rec);
    end
    if (fill) begin
      // newest-year record at index 0 pairs with all others
      query_rec(0);
      query_rec(MAX_RECORDS - 1);
      query_rec($urandom_range(MAX_RECORDS - 1));
    end else begin
      for (int i = 0; i < records_held; i++) query_rec(i);
      query_rec($urandom_range(records_held, 63));
    end
  endtask

  initial begin
    int phase_pct [3];
    phase_pct    = '{0, 46, 31};
    items_sent   = 0;
    records_held = 0;
    idle_pct     = 0;
    rst         <= 1'b1;
    start       <= 1'b0;
    cmd         <= CMD_CLEAR;
    year        <= '0;
    location    <= '0;
    stratum     <= '0;
    source      <= '0;
    query_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, unused command, key and year corner cases
    query_rec(0);
    control(CMD_UNUSED);
    append_rec('{year: 16'd0, location: 16'd0, stratum: 16'd0, source: 16'd0});
    append_rec('{year: 16'd1, location: 16'd0, stratum: 16'd0, source: 16'd0});
    append_rec('{year: 16'hFFFF, location: 16'hFFFF, stratum: 16'hFFFF, source: 16'hFFFF});
    append_rec('{year: 16'hFFFE, location: 16'hFFFF, stratum: 16'hFFFF, source: 16'hFFFF});
    // year 0 must not pair with the top year (no wrap)
    append_rec('{year: 16'd0, location: 16'hFFFF, stratum: 16'hFFFF, source: 16'hFFFF});
    append_rec('{year: 16'd0, location: 16'd0, stratum: 16'd0, source: 16'd0});
    // one key field off each
    append_rec('{year: 16'd1, location: 16'd0, stratum: 16'd1, source: 16'd0});
    append_rec('{year: 16'd1, location: 16'd1, stratum: 16'd0, source: 16'd0});
    append_rec('{year: 16'd1, location: 16'd0, stratum: 16'd0, source: 16'd1});
    for (int i = 0; i < 9; i++) query_rec(i);
    query_rec(9);
    query_rec(63);
    control(CMD_CLEAR);
    query_rec(0);

    // random table builds; the full-table build runs once in the idle phase
    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_pct[p];
      run_scenario(p == 1);
      while (items_sent < 24 + (p + 1) * ITEMS_PER_PHASE) run_scenario(1'b0);
      wait_results_done();
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
